@@ src/assert_macros.svh @@
// Assertion macros shared by the parser RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MBSP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mbsp: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define MBSP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mbsp: next-cycle check failed");

`endif

@@ src/mbsp_pkg.sv @@
// Types, constants and helpers for the MIDI byte stream parser.
// No dependencies; used by every module of the block except mbsp_ram.
package mbsp_pkg;

    localparam int SYSEX_DEPTH = 256;
    localparam int ADDR_W      = $clog2(SYSEX_DEPTH);
    localparam int CNT_W       = $clog2(SYSEX_DEPTH + 1);
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic       KIND_RX   = 1'b0;
    localparam logic       KIND_READ = 1'b1;

    localparam logic [1:0] RK_MESSAGE = 2'd0;
    localparam logic [1:0] RK_SYSEX   = 2'd1;
    localparam logic [1:0] RK_READ    = 2'd2;

    localparam logic [7:0] ST_STATUS_MIN   = 8'h80;
    localparam logic [7:0] ST_CHAN_MAX     = 8'hEF;
    localparam logic [7:0] ST_SYSEX_START  = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END    = 8'hF7;
    localparam logic [7:0] ST_REALTIME_MIN = 8'hF8;
    localparam logic [7:0] CHAN_MASK       = 8'h0F;
    localparam logic [4:0] NO_CHANNEL      = 5'd16;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
        logic [7:0] read_index;
    } in_word_t;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
        logic [4:0] channel_number;
        logic [8:0] sysex_length;
        logic [7:0] read_data;
    } out_word_t;

    // One queued command: optional buffer write, optional buffer read,
    // optional result (read data filled in by the back end).
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              res_en;
        out_word_t         res;
    } cmd_t;

    // Total message length for a status byte; 0 means not a message start.
    function automatic logic [1:0] status_length(input logic [7:0] st);
        logic [1:0] len;
        len = 2'd0;
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: len = 2'd3;
            4'hC, 4'hD:                   len = 2'd2;
            4'hF:
            begin
                case (st[3:0])
                    4'h1, 4'h3: len = 2'd2;
                    4'h2:       len = 2'd3;
                    4'h6:       len = 2'd1;
                    default:    len = st[3] ? 2'd1 : 2'd0;
                endcase
            end
            default: len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic out_word_t make_message(input logic [7:0] st,
                                               input logic [6:0] d1,
                                               input logic [6:0] d2);
        out_word_t w;
        w = '0;
        w.result_kind = RK_MESSAGE;
        w.status_byte = st;
        w.first_data  = d1;
        w.second_data = d2;
        if (st >= ST_STATUS_MIN && st <= ST_CHAN_MAX)
        begin
            w.channel_number = {1'b0, st[3:0] & CHAN_MASK[3:0]};
        end
        else
        begin
            w.channel_number = NO_CHANNEL;
        end
        return w;
    endfunction

endpackage

@@ src/mbsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ src/mbsp_front.sv @@
// Front end: classifies each input word, keeps parser and SysEx state,
// and emits one command per word that needs a write or a result. Uses mbsp_pkg.
module mbsp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mbsp_pkg::in_word_t in_word,
    input  logic              push,
    output logic              full,
    output mbsp_pkg::cmd_t    cmd_word,
    output logic              cmd_push,
    input  logic              cmd_full
);
    import mbsp_pkg::*;

    logic [7:0]       rs_reg, rs_next;
    logic [7:0]       held_st_reg, held_st_next;
    logic [6:0]       held_d1_reg, held_d1_next;
    logic [1:0]       bc_reg, bc_next;
    logic [1:0]       ml_reg, ml_next;
    logic             in_sx_reg, in_sx_next;
    logic [CNT_W-1:0] sx_cnt_reg, sx_cnt_next;

    logic       accept;
    logic [7:0] b;
    logic [1:0] len;
    logic       can_store;
    logic       handle;
    logic [1:0] bc_v;
    logic [7:0] held_v;
    logic [1:0] ml_v;
    cmd_t       cmd;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign b        = in_word.rx_byte;
    assign len      = status_length(b);
    assign can_store = sx_cnt_reg < CNT_W'(SYSEX_DEPTH);

    always_comb
    begin
        rs_next      = rs_reg;
        held_st_next = held_st_reg;
        held_d1_next = held_d1_reg;
        bc_next      = bc_reg;
        ml_next      = ml_reg;
        in_sx_next   = in_sx_reg;
        sx_cnt_next  = sx_cnt_reg;
        cmd          = '0;
        handle       = 1'b0;
        bc_v         = bc_reg;
        held_v       = held_st_reg;
        ml_v         = ml_reg;

        if (in_word.kind == KIND_READ)
        begin
            cmd.res_en              = 1'b1;
            cmd.res.result_kind     = RK_READ;
            cmd.res.channel_number  = NO_CHANNEL;
            cmd.rd_en   = 32'(in_word.read_index) < 32'(SYSEX_DEPTH);
            cmd.rd_addr = ADDR_W'(in_word.read_index);
        end
        else if (b >= ST_REALTIME_MIN)
        begin
            cmd.res_en = 1'b1;
            cmd.res    = make_message(b, 7'd0, 7'd0);
        end
        else
        begin
            handle = 1'b1;
            if (in_sx_reg)
            begin
                if (b == ST_SYSEX_END)
                begin
                    handle                 = 1'b0;
                    cmd.wr_en              = can_store;
                    cmd.wr_addr            = sx_cnt_reg[ADDR_W-1:0];
                    cmd.wr_data            = b;
                    cmd.res_en             = 1'b1;
                    cmd.res.result_kind    = RK_SYSEX;
                    cmd.res.status_byte    = ST_SYSEX_START;
                    cmd.res.channel_number = NO_CHANNEL;
                    cmd.res.sysex_length   = 9'(sx_cnt_reg + CNT_W'(can_store));
                    in_sx_next             = 1'b0;
                    sx_cnt_next            = '0;
                    rs_next                = '0;
                end
                else if (b[7])
                begin
                    // abort, then treat as a fresh status
                    in_sx_next  = 1'b0;
                    sx_cnt_next = '0;
                end
                else
                begin
                    handle      = 1'b0;
                    cmd.wr_en   = can_store;
                    cmd.wr_addr = sx_cnt_reg[ADDR_W-1:0];
                    cmd.wr_data = b;
                    sx_cnt_next = sx_cnt_reg + CNT_W'(can_store);
                end
            end

            if (handle)
            begin
                if (b == ST_SYSEX_START)
                begin
                    in_sx_next  = 1'b1;
                    cmd.wr_en   = 1'b1;
                    cmd.wr_addr = '0;
                    cmd.wr_data = b;
                    sx_cnt_next = CNT_W'(1);
                    rs_next     = '0;
                    bc_next     = '0;
                end
                else if (b[7])
                begin
                    bc_next = '0;
                    if (len == 2'd1)
                    begin
                        rs_next    = '0;
                        cmd.res_en = 1'b1;
                        cmd.res    = make_message(b, 7'd0, 7'd0);
                    end
                    else if (len != 2'd0)
                    begin
                        held_st_next = b;
                        bc_next      = 2'd1;
                        ml_next      = len;
                        rs_next      = (b <= ST_CHAN_MAX) ? b : 8'd0;
                    end
                end
                else
                begin
                    // data byte; running status may start a new message
                    if (bc_reg == 2'd0 && rs_reg != 8'd0)
                    begin
                        held_v = rs_reg;
                        bc_v   = 2'd1;
                        ml_v   = status_length(rs_reg);
                    end
                    held_st_next = held_v;
                    ml_next      = ml_v;
                    if (bc_v == 2'd1)
                    begin
                        held_d1_next = b[6:0];
                        if (ml_v <= 2'd2)
                        begin
                            bc_next    = 2'd0;
                            cmd.res_en = 1'b1;
                            cmd.res    = make_message(held_v, b[6:0], 7'd0);
                        end
                        else
                        begin
                            bc_next = 2'd2;
                        end
                    end
                    else if (bc_v != 2'd0)
                    begin
                        bc_next    = 2'd0;
                        cmd.res_en = 1'b1;
                        cmd.res    = make_message(held_v, held_d1_reg, b[6:0]);
                    end
                end
            end
        end
    end

    assign cmd_word = cmd;
    assign cmd_push = accept && (cmd.wr_en || cmd.res_en);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg      <= '0;
            held_st_reg <= '0;
            held_d1_reg <= '0;
            bc_reg      <= '0;
            ml_reg      <= '0;
            in_sx_reg   <= 1'b0;
            sx_cnt_reg  <= '0;
        end
        else if (accept)
        begin
            rs_reg      <= rs_next;
            held_st_reg <= held_st_next;
            held_d1_reg <= held_d1_next;
            bc_reg      <= bc_next;
            ml_reg      <= ml_next;
            in_sx_reg   <= in_sx_next;
            sx_cnt_reg  <= sx_cnt_next;
        end
    end

endmodule

@@ src/mbsp_cmd_queue.sv @@
// Short command queue between front and back end.
// Uses mbsp_pkg (cmd_t, CMD_DEPTH).
module mbsp_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  mbsp_pkg::cmd_t wr_word,
    input  logic           wr_en,
    output logic           full,
    output mbsp_pkg::cmd_t rd_word,
    input  logic           rd_en,
    output logic           empty
);
    import mbsp_pkg::*;

    cmd_t                 slots [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] head_reg, head_next;
    logic [CMD_PTR_W-1:0] tail_reg, tail_next;
    logic [CMD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = cnt_reg == CMD_CNT_W'(CMD_DEPTH);
    assign empty   = cnt_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_word = slots[head_reg];

    always_comb
    begin
        head_next = do_rd ? head_reg + CMD_PTR_W'(1) : head_reg;
        tail_next = do_wr ? tail_reg + CMD_PTR_W'(1) : tail_reg;
        cnt_next  = cnt_reg + CMD_CNT_W'(do_wr) - CMD_CNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[tail_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

@@ src/mbsp_back.sv @@
// Back end: runs queued commands against the SysEx buffer and queues results.
// Uses mbsp_pkg and mbsp_ram.
module mbsp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mbsp_pkg::cmd_t     cmd_word,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output mbsp_pkg::out_word_t out_word,
    output logic               empty,
    input  logic               pop
);
    import mbsp_pkg::*;

    logic [7:0]           ram_q;
    logic                 s1_res_reg;
    logic                 s1_rd_reg;
    out_word_t            s1_word_reg;
    out_word_t            push_word;
    out_word_t            slots [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] head_reg, head_next;
    logic [OUT_PTR_W-1:0] tail_reg, tail_next;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 do_pop;

    // reserve a slot for the result still in the read stage
    assign cmd_pop = !cmd_empty &&
        ((OUT_CNT_W+1)'(cnt_reg) + (OUT_CNT_W+1)'(s1_res_reg)
         < (OUT_CNT_W+1)'(OUT_DEPTH));

    mbsp_ram #(
        .WIDTH (8),
        .DEPTH (SYSEX_DEPTH)
    ) u_sysex_ram (
        .clk   (clk),
        .we    (cmd_pop && cmd_word.wr_en),
        .waddr (cmd_word.wr_addr),
        .wdata (cmd_word.wr_data),
        .re    (cmd_pop && cmd_word.rd_en),
        .raddr (cmd_word.rd_addr),
        .rdata (ram_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            s1_word_reg <= cmd_word.res;
            s1_rd_reg   <= cmd_word.rd_en;
        end
    end

    always_comb
    begin
        push_word = s1_word_reg;
        if (s1_rd_reg)
        begin
            push_word.read_data = ram_q;
        end
    end

    assign empty    = cnt_reg == '0;
    assign do_pop   = pop && !empty;
    assign out_word = slots[head_reg];

    always_comb
    begin
        head_next = do_pop ? head_reg + OUT_PTR_W'(1) : head_reg;
        tail_next = s1_res_reg ? tail_reg + OUT_PTR_W'(1) : tail_reg;
        cnt_next  = cnt_reg + OUT_CNT_W'(s1_res_reg) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (s1_res_reg)
        begin
            slots[tail_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_res_reg <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            s1_res_reg <= cmd_pop && cmd_word.res_en;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

@@ src/midi_byte_stream_parser_core.sv @@
// MIDI byte stream parser, top level: front end, command queue, back end.
// Uses mbsp_pkg, mbsp_front, mbsp_cmd_queue, mbsp_back, assert_macros.svh.
//
// Usage:
//   Input queue: drive in_word and raise push; a word is taken on a clock
//   edge with push high and full low. kind 0 carries a received MIDI byte,
//   kind 1 asks for one byte of the SysEx buffer.
//   Result queue: while empty is low, out_word holds the oldest result;
//   raise pop to take it. Words that produce no result (data bytes of an
//   unfinished message, SysEx body bytes, ignored status) yield nothing.
//   Throughput: one input word per cycle, sustained, as long as results are
//   drained; the parser state is updated once for each accepted byte.
//   A result passes the command queue and the buffer read stage before it
//   shows on out_word, and can be popped on the next edge.
//   When the receiver stalls, the 4-deep result queue fills, the back end
//   stops draining the 4-deep command queue, and full rises once it is full.
//   Reset clears parser state and both queues. The SysEx buffer is not
//   cleared; only entries written since reset hold defined data.
`include "assert_macros.svh"

module midi_byte_stream_parser_core (
    input  logic                clk,
    input  logic                rst_n,
    input  mbsp_pkg::in_word_t  in_word,
    input  logic                push,
    output logic                full,
    output mbsp_pkg::out_word_t out_word,
    output logic                empty,
    input  logic                pop
);
    import mbsp_pkg::*;

    cmd_t front_cmd;
    logic front_cmd_push;
    logic cmd_full;
    cmd_t back_cmd;
    logic cmd_empty;
    logic back_cmd_pop;

    mbsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in_word),
        .push     (push),
        .full     (full),
        .cmd_word (front_cmd),
        .cmd_push (front_cmd_push),
        .cmd_full (cmd_full)
    );

    mbsp_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_word (front_cmd),
        .wr_en   (front_cmd_push),
        .full    (cmd_full),
        .rd_word (back_cmd),
        .rd_en   (back_cmd_pop),
        .empty   (cmd_empty)
    );

    mbsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (back_cmd_pop),
        .out_word  (out_word),
        .empty     (empty),
        .pop       (pop)
    );

    `MBSP_ASSERT_IMP(a_cmd_no_overflow, front_cmd_push, !cmd_full)
    `MBSP_ASSERT_IMP(a_read_result_shape,
        !empty && out_word.result_kind == RK_READ,
        out_word.channel_number == NO_CHANNEL && out_word.sysex_length == 9'd0)
    `MBSP_ASSERT_IMP(a_sysex_result_shape,
        !empty && out_word.result_kind == RK_SYSEX,
        out_word.sysex_length != 9'd0 && out_word.status_byte == ST_SYSEX_START)
    `MBSP_ASSERT_NXT(a_pop_only_when_queued, back_cmd_pop, !$past(cmd_empty))

endmodule
